// ===== sv/dcq_pkg.sv =====
// shared constants, types and helpers for the deduplicating command queue
// used by every module of the block but dcq_ram; no dependencies

package dcq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int CODE_W      = 8;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CODE_W-1:0] code_t;

  localparam code_t CMD_NONE  = 8'd0;
  localparam code_t CMD_START = 8'd1;
  localparam code_t CMD_STOP  = 8'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;      // latch the incoming item
    logic pop;         // drop the head if any
    logic start_pass;  // arm a compaction pass
    logic pass_purge;  // the armed pass removes start commands
    logic scan;        // run one step of the current pass
    logic append;      // store the command at the tail if room
    logic load_result; // move the result into the output register
  } dcq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_pop;
    logic code_zero;
    logic code_stop;
    logic scan_done;
    logic out_free;
  } dcq_stat_t;

  // base + offset modulo the depth, for base < depth and offset <= depth
  function automatic idx_t wrap_add(idx_t base, cnt_t off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(QUEUE_DEPTH)) s = s - SUM_W'(QUEUE_DEPTH);
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== sv/dcq_req_if.sv =====
// request and response channels of the deduplicating command queue
// depends on dcq_pkg

interface dcq_req_if;
  logic            valid;
  logic            ready;
  logic            operation;
  dcq_pkg::code_t  command;

  modport source (output valid, operation, command, input ready);
  modport sink   (input valid, operation, command, output ready);
endinterface

interface dcq_rsp_if;
  logic            valid;
  logic            ready;
  dcq_pkg::code_t  head_command;
  logic            accepted;
  logic            start_purged;

  modport source (output valid, head_command, accepted, start_purged, input ready);
  modport sink   (input valid, head_command, accepted, start_purged, output ready);
endinterface

// ===== sv/dcq_ram.sv =====
// generic simple dual-port RAM: one write port, one read port, registered read
// no dependencies

module dcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/dcq_ctrl.sv =====
// sequencing state machine of the deduplicating command queue
// depends on dcq_pkg; drives dcq_datapath through dcq_cmd_t

module dcq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  dcq_pkg::dcq_stat_t stat,
  output dcq_pkg::dcq_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_PURGE    = 7'b0000100,
    S_DEDUP    = 7'b0001000,
    S_APPEND   = 7'b0010000,
    S_HEAD     = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (stat.op_pop) begin
          cmd.pop    = 1'b1;
          state_next = S_HEAD;
        end else if (stat.code_zero) begin
          state_next = S_HEAD;
        end else if (stat.code_stop) begin
          cmd.start_pass = 1'b1;
          cmd.pass_purge = 1'b1;
          state_next     = S_PURGE;
        end else begin
          cmd.start_pass = 1'b1;
          state_next     = S_DEDUP;
        end
      end
      S_PURGE: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          cmd.start_pass = 1'b1;
          state_next     = S_DEDUP;
        end
      end
      S_DEDUP: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_next = S_APPEND;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_HEAD;
      end
      S_HEAD: begin
        // read address rests on the head here
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/dcq_datapath.sv =====
// queue storage, pointers, compaction pass and result register
// depends on dcq_pkg, dcq_rsp_if and dcq_ram; driven by dcq_ctrl

module dcq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               operation,
  input  dcq_pkg::code_t     command,
  input  dcq_pkg::dcq_cmd_t  cmd,
  output dcq_pkg::dcq_stat_t stat,
  dcq_rsp_if.source          response
);

  dcq_pkg::idx_t  hd;       // physical slot of the head
  dcq_pkg::cnt_t  n;        // occupied entries
  dcq_pkg::cnt_t  r;        // next logical slot to read in a pass
  dcq_pkg::cnt_t  w;        // next logical slot to write in a pass
  logic           rv;       // read data holds the entry read last cycle
  logic           hit;
  logic           pass_purge;
  logic           op;
  dcq_pkg::code_t code;
  logic           acc;
  logic           purged;
  logic           out_valid;
  dcq_pkg::code_t out_head;
  logic           out_acc;
  logic           out_purged;

  dcq_pkg::code_t match;
  logic           more;
  logic           keep;
  logic           wr_en;
  dcq_pkg::idx_t  wr_addr;
  dcq_pkg::code_t wr_data;
  dcq_pkg::idx_t  rd_addr;
  dcq_pkg::code_t rd_data;

  assign match = pass_purge ? dcq_pkg::CMD_START : code;
  assign more  = (r < n);
  assign keep  = cmd.scan && rv && (rd_data != match);

  assign rd_addr = cmd.scan ? dcq_pkg::wrap_add(hd, r) : hd;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = dcq_pkg::wrap_add(hd, w);
    wr_data = rd_data;
    if (keep) begin
      wr_en = 1'b1;
    end else if (cmd.append && (n < dcq_pkg::CNT_W'(dcq_pkg::QUEUE_DEPTH))) begin
      wr_en   = 1'b1;
      wr_addr = dcq_pkg::wrap_add(hd, n);
      wr_data = code;
    end
  end

  dcq_ram #(
    .WIDTH (dcq_pkg::CODE_W),
    .DEPTH (dcq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign stat.op_pop    = (op == dcq_pkg::OP_POP);
  assign stat.code_zero = (code == dcq_pkg::CMD_NONE);
  assign stat.code_stop = (code == dcq_pkg::CMD_STOP);
  assign stat.scan_done = !more && !rv;
  assign stat.out_free  = !out_valid || response.ready;

  // queue control state
  always_ff @(posedge clk) begin
    if (rst) begin
      hd <= '0;
      n  <= '0;
      rv <= 1'b0;
    end else begin
      if (cmd.pop && (n != '0)) begin
        hd <= dcq_pkg::wrap_add(hd, dcq_pkg::CNT_W'(1));
        n  <= n - dcq_pkg::CNT_W'(1);
      end
      if (cmd.scan) begin
        // head slot is never compared, so an empty queue stays empty
        if (stat.scan_done && (n != '0)) n <= w;
      end
      if (cmd.start_pass) rv <= 1'b0;
      else if (cmd.scan)  rv <= more;
      if (cmd.append && (n < dcq_pkg::CNT_W'(dcq_pkg::QUEUE_DEPTH))) n <= n + dcq_pkg::CNT_W'(1);
    end
  end

  // pass and item working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op     <= operation;
      code   <= command;
      acc    <= 1'b0;
      purged <= 1'b0;
    end
    if (cmd.scan) begin
      if (more) r <= r + dcq_pkg::CNT_W'(1);
      if (keep) w <= w + dcq_pkg::CNT_W'(1);
      if (rv && !keep) hit <= 1'b1;
      if (stat.scan_done && pass_purge) purged <= hit;
    end
    if (cmd.start_pass) begin
      r          <= dcq_pkg::CNT_W'(1);
      w          <= dcq_pkg::CNT_W'(1);
      hit        <= 1'b0;
      pass_purge <= cmd.pass_purge;
    end
    if (cmd.append) acc <= (n < dcq_pkg::CNT_W'(dcq_pkg::QUEUE_DEPTH));
  end

  // result register, free to take a transfer while the next item runs
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_head   <= (n == '0) ? dcq_pkg::CMD_NONE : rd_data;
      out_acc    <= acc;
      out_purged <= purged;
    end
  end

  assign response.valid        = out_valid;
  assign response.head_command = out_head;
  assign response.accepted     = out_acc;
  assign response.start_purged = out_purged;

endmodule

// ===== sv/dedup_command_queue.sv =====
// Ordered queue of nonzero command codes held in a circular RAM with a head
// pointer and an occupancy count. A pop, or a push of code zero, goes through
// the head state to the done state, where its result enters the output
// register once that is free. A push runs one compaction pass over the
// occupied entries behind the head, reading one entry a cycle through the
// single RAM read port; a push of the stop command runs a purge pass for
// start commands first. The next request is taken as the result enters the
// output register, even while that result still waits for its transfer.
// Reset empties the queue at once through the count; no RAM clearing pass.
// depends on dcq_pkg, dcq_req_if, dcq_rsp_if, dcq_ctrl, dcq_datapath

module dedup_command_queue (
  input  logic      clk,
  input  logic      rst,
  dcq_req_if.sink   request,
  dcq_rsp_if.source response
);

  dcq_pkg::dcq_cmd_t  cmd;
  dcq_pkg::dcq_stat_t stat;

  dcq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dcq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .operation (request.operation),
    .command   (request.command),
    .cmd       (cmd),
    .stat      (stat),
    .response  (response)
  );

endmodule
